>>> hw/rtl/sfl_pkg.sv
package sfl_pkg;

   // Sizes of the item fields and defaults of the top-level parameters.
   localparam int MAX_TAPS_DEF   = 256;
   localparam int COEF_FRAC_BITS = 17;
   localparam int SAMPLE_W       = 16;
   localparam int COEF_W         = 18;
   localparam int IDX_W          = 8;
   localparam int TAP_W          = 9;
   localparam int TAP_RESET      = 192;
   localparam int PROD_W         = SAMPLE_W + COEF_W;
   localparam int QUEUE_DEPTH    = 4;
   localparam int REQ_DATA_W     = 64;
   localparam int RSP_DATA_W     = 32;

   // Command carried in req_tuser.
   typedef enum logic [1:0] {
      CMD_FILTER = 2'd0,
      CMD_LOAD   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   // One queued item as the back end sees it.
   typedef struct packed {
      cmd_type                     cmd;
      logic signed [SAMPLE_W-1:0]  left;
      logic signed [SAMPLE_W-1:0]  right;
      logic [IDX_W-1:0]            idx;
      logic signed [COEF_W-1:0]    coef;
   } item_type;

   // Head of the queue toward the back end.
   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

   // Status from the back end toward the front end.
   typedef struct packed {
      logic pop;
      logic init_busy;
   } back_stat_type;

   // Back-end sequencer states.
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_LOAD,
      ST_CLEAR,
      ST_WRITE,
      ST_MAC,
      ST_DRAIN,
      ST_SCALE,
      ST_OUT
   } state_type;

endpackage

>>> hw/rtl/sfl_front.sv
module sfl_front import sfl_pkg::*; #(
   parameter int MAX_TAPS = MAX_TAPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // left_sample [15:0], right_sample [31:16], coef_index [39:32],
   // coef_value [57:40], zero [63:58]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd [1:0]
   input  logic [1:0]            req_tuser,
   input  back_stat_type         stat,
   output qhead_type             qhead
);

   localparam int QA_W = $clog2(QUEUE_DEPTH);
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

   item_type          item_in;
   logic              keep;
   logic              push;
   logic              accept;
   item_type          mem_ff [QUEUE_DEPTH];
   logic [QA_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QA_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]   cnt_ff, cnt_in;

   // Unpack the item and decide whether it has any effect.
   always_comb begin
      item_in.cmd   = cmd_type'(req_tuser);
      item_in.left  = req_tdata[15:0];
      item_in.right = req_tdata[31:16];
      item_in.idx   = req_tdata[39:32];
      item_in.coef  = req_tdata[57:40];
      case (item_in.cmd)
         CMD_FILTER: keep = 1'b1;
         CMD_CLEAR:  keep = 1'b1;
         CMD_LOAD:   keep = (32'(item_in.idx) < 32'(MAX_TAPS));
         default:    keep = 1'b0;
      endcase
   end

   assign req_tready = (cnt_ff != QC_W'(QUEUE_DEPTH)) && !stat.init_busy;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && keep;

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (stat.pop) begin
         rd_ptr_in = (rd_ptr_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !stat.pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && stat.pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign qhead.valid = (cnt_ff != '0);
   assign qhead.item  = mem_ff[rd_ptr_ff];

endmodule

>>> hw/rtl/sfl_back.sv
module sfl_back import sfl_pkg::*; #(
   parameter int MAX_TAPS = MAX_TAPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [TAP_W-1:0]      tap_count,
   input  qhead_type             qhead,
   output back_stat_type         stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW    = $clog2(MAX_TAPS);
   localparam int CW    = $clog2(MAX_TAPS + 1);
   localparam int TCW   = (CW > TAP_W) ? CW : TAP_W;
   localparam int ACC_W = PROD_W + 1 + $clog2(MAX_TAPS);
   localparam int QW    = ACC_W - COEF_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] BIAS =
      ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);
   localparam logic signed [QW-1:0] SAT_HI = QW'(32767);
   localparam logic signed [QW-1:0] SAT_LO = QW'(-32768);

   state_type                   state_ff, state_in;
   item_type                    item_ff, item_in;
   logic [AW-1:0]               ptr_ff, ptr_in;
   logic [AW-1:0]               slot_ff, slot_in;
   logic [AW-1:0]               clr_ff, clr_in;
   logic [CW-1:0]               k_ff, k_in;
   logic [CW-1:0]               taps_ff, taps_in;
   logic [TCW-1:0]              taps_ext;

   logic signed [SAMPLE_W-1:0]  hl_mem [MAX_TAPS];
   logic signed [SAMPLE_W-1:0]  hr_mem [MAX_TAPS];
   logic signed [COEF_W-1:0]    c_mem  [MAX_TAPS];
   logic                        hist_we, coef_we, rd_en;
   logic [AW-1:0]               hist_waddr, coef_waddr;
   logic signed [SAMPLE_W-1:0]  hl_wdata, hr_wdata;
   logic signed [COEF_W-1:0]    c_wdata;
   logic signed [SAMPLE_W-1:0]  hl_rd_ff, hr_rd_ff;
   logic signed [COEF_W-1:0]    c_rd_ff;

   logic                        v1_ff, v2_ff;
   logic signed [PROD_W-1:0]    pl_ff, pr_ff;
   logic signed [ACC_W-1:0]     accl_ff, accl_in;
   logic signed [ACC_W-1:0]     accr_ff, accr_in;
   logic signed [ACC_W-1:0]     biased_l, biased_r;
   logic signed [QW-1:0]        ql_ff, ql_in;
   logic signed [QW-1:0]        qr_ff, qr_in;
   logic signed [SAMPLE_W-1:0]  sat_l, sat_r;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                        out_free;
   logic                        clr_last;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign clr_last = (clr_ff == AW'(MAX_TAPS - 1));
   assign taps_ext = TCW'(tap_count);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (qhead.valid) begin
               case (qhead.item.cmd)
                  CMD_FILTER: state_in = ST_WRITE;
                  CMD_LOAD:   state_in = ST_LOAD;
                  CMD_CLEAR:  state_in = ST_CLEAR;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD:  state_in = ST_IDLE;
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_WRITE: state_in = (taps_ff == '0) ? ST_DRAIN : ST_MAC;
         ST_MAC: begin
            if (k_ff == taps_ff - CW'(1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) state_in = ST_SCALE;
         end
         ST_SCALE: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Saturation of the scaled sums.
   always_comb begin
      if (ql_ff > SAT_HI) begin
         sat_l = SAMPLE_W'(SAT_HI);
      end else if (ql_ff < SAT_LO) begin
         sat_l = SAMPLE_W'(SAT_LO);
      end else begin
         sat_l = SAMPLE_W'(ql_ff);
      end
      if (qr_ff > SAT_HI) begin
         sat_r = SAMPLE_W'(SAT_HI);
      end else if (qr_ff < SAT_LO) begin
         sat_r = SAMPLE_W'(SAT_LO);
      end else begin
         sat_r = SAMPLE_W'(qr_ff);
      end
   end

   // Divide by the coefficient scale, truncating toward zero.
   assign biased_l = accl_ff + (accl_ff[ACC_W-1] ? BIAS : '0);
   assign biased_r = accr_ff + (accr_ff[ACC_W-1] ? BIAS : '0);

   // Sequencer outputs and datapath next values.
   always_comb begin
      item_in      = item_ff;
      ptr_in       = ptr_ff;
      slot_in      = slot_ff;
      clr_in       = clr_ff;
      k_in         = k_ff;
      taps_in      = taps_ff;
      ql_in        = ql_ff;
      qr_in        = qr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      stat.pop       = 1'b0;
      stat.init_busy = (state_ff == ST_INIT);
      hist_we      = 1'b0;
      hist_waddr   = clr_ff;
      hl_wdata     = '0;
      hr_wdata     = '0;
      coef_we      = 1'b0;
      coef_waddr   = clr_ff;
      c_wdata      = '0;
      rd_en        = 1'b0;
      case (state_ff)
         ST_INIT: begin
            hist_we = 1'b1;
            coef_we = 1'b1;
            ptr_in  = '0;
            clr_in  = clr_last ? '0 : clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (qhead.valid) begin
               stat.pop = 1'b1;
               item_in  = qhead.item;
               clr_in   = '0;
               taps_in  = (taps_ext > TCW'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(tap_count);
            end
         end
         ST_LOAD: begin
            coef_we    = 1'b1;
            coef_waddr = AW'(item_ff.idx);
            c_wdata    = item_ff.coef;
         end
         ST_CLEAR: begin
            hist_we = 1'b1;
            ptr_in  = '0;
            clr_in  = clr_last ? '0 : clr_ff + 1'b1;
         end
         ST_WRITE: begin
            hist_we    = 1'b1;
            hist_waddr = ptr_ff;
            hl_wdata   = item_ff.left;
            hr_wdata   = item_ff.right;
            slot_in    = ptr_ff;
            k_in       = '0;
            ptr_in     = (ptr_ff == AW'(MAX_TAPS - 1)) ? '0 : ptr_ff + 1'b1;
         end
         ST_MAC: begin
            rd_en   = 1'b1;
            k_in    = k_ff + 1'b1;
            slot_in = (slot_ff == '0) ? AW'(MAX_TAPS - 1) : slot_ff - 1'b1;
         end
         ST_SCALE: begin
            ql_in = QW'(biased_l >>> COEF_FRAC_BITS);
            qr_in = QW'(biased_r >>> COEF_FRAC_BITS);
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {sat_r, sat_l};
            end
         end
         default: begin
         end
      endcase
   end

   // Accumulators: cleared when a filter item starts, fed by the product stage.
   always_comb begin
      accl_in = accl_ff;
      accr_in = accr_ff;
      if (state_ff == ST_WRITE) begin
         accl_in = '0;
         accr_in = '0;
      end else if (v2_ff) begin
         accl_in = accl_ff + ACC_W'(pl_ff);
         accr_in = accr_ff + ACC_W'(pr_ff);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ptr_ff       <= '0;
         clr_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         clr_ff       <= clr_in;
         v1_ff        <= rd_en;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers and the multiply stage.
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      slot_ff     <= slot_in;
      k_ff        <= k_in;
      taps_ff     <= taps_in;
      accl_ff     <= accl_in;
      accr_ff     <= accr_in;
      ql_ff       <= ql_in;
      qr_ff       <= qr_in;
      rsp_data_ff <= rsp_data_in;
      if (v1_ff) begin
         pl_ff <= c_rd_ff * hl_rd_ff;
         pr_ff <= c_rd_ff * hr_rd_ff;
      end
   end

   // History memories.
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hl_mem[hist_waddr] <= hl_wdata;
         hr_mem[hist_waddr] <= hr_wdata;
      end
      if (rd_en) begin
         hl_rd_ff <= hl_mem[slot_ff];
         hr_rd_ff <= hr_mem[slot_ff];
      end
   end

   // Coefficient memory.
   always_ff @(posedge clock) begin
      if (coef_we) begin
         c_mem[coef_waddr] <= c_wdata;
      end
      if (rd_en) begin
         c_rd_ff <= c_mem[k_ff[AW-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/stereo_fir_lowpass.sv
// Stereo FIR low-pass filter: both channels share one table of signed Q1.17
// coefficients and each keeps a ring of past samples. A filter item (cmd 0)
// yields one result, y = sum of c[k]*x[n-k] over the taps in use, divided by
// 2^17 with truncation toward zero and saturated to 16 bits; a coefficient
// load (cmd 1) and a history clear (cmd 2) yield none, and cmd 3 is dropped.
// Items enter a four-deep queue, so the input side keeps accepting while the
// back end works. One multiply-accumulate unit per channel walks the taps,
// one tap per cycle, through memories with separate read and write ports.
// After reset, the histories and coefficients are zeroed by a sweep over all
// MAX_TAPS entries, during which no item is accepted; tap_count may be
// written then. tap_count resets to 192; values above MAX_TAPS act as
// MAX_TAPS.
module stereo_fir_lowpass import sfl_pkg::*; #(
   parameter int MAX_TAPS = MAX_TAPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // left_sample [15:0], right_sample [31:16], coef_index [39:32],
   // coef_value [57:40], zero [63:58]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd [1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // left_out [15:0], right_out [31:16]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [TAP_W-1:0]      csr_data
);

   logic [TAP_W-1:0] tap_count_ff;
   back_stat_type    stat;
   qhead_type        qhead;

   // Tap count register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_W'(TAP_RESET);
      end else if (csr_valid && csr_ready) begin
         tap_count_ff <= csr_data;
      end
   end

   sfl_front #(
      .MAX_TAPS (MAX_TAPS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .qhead      (qhead)
   );

   sfl_back #(
      .MAX_TAPS (MAX_TAPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .tap_count  (tap_count_ff),
      .qhead      (qhead),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
